/* rtl/csr_pkg.sv */
`default_nettype none
// ============================================================================
// csr_pkg : shared definitions for the cubic spline segment rasteriser
// Default sizes, coefficient format, register indexes and the command and
// status bundles passed between controller and datapath.
// ============================================================================
package csr_pkg;

    // default sizes for the top-level parameters
    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // basis matrix coefficients: signed Q3.12, four per row, four rows
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 12;
    localparam int NUM_CP    = 4;

    // configuration port
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int POINT_COUNT_W = 7;
    localparam int COLOR_W       = 4;

    localparam logic [POINT_COUNT_W-1:0] POINT_COUNT_RST = 7'd64;
    localparam logic [COLOR_W-1:0]       PIXEL_COLOR_RST = 4'd15;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BASIS_ROW_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASIS_ROW_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASIS_ROW_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASIS_ROW_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COLOR = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture control points, restart t
        logic div_start;  // start the t-step division
        logic issue;      // push one pixel into the pipeline
        logic last;       // pixel being issued is the final one
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;   // step division finished (one-cycle pulse)
        logic pipe_en;    // pipeline advances this cycle
        logic pipe_empty; // nothing in flight, output register empty
    } dp_status_t;

endpackage
`default_nettype wire

/* rtl/csr_div.sv */
`default_nettype none
// ============================================================================
// csr_div : restoring divider for the parameter step
// Works out 2^FRAC_BITS / divisor one quotient bit per cycle, giving the
// whole part and remainder used by the incremental t generator.
// ============================================================================
module csr_div import csr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DIV_W     = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_W-1:0]     divisor,
    output logic                 done,
    output logic [FRAC_BITS:0]   quot,
    output logic [DIV_W-1:0]     rem
);

    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [FRAC_BITS:0]   quot_reg;
    logic [DIV_W-1:0]     rem_reg;

    logic                 num_bit;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;
    logic                 fits;

    // one restoring step; the dividend has only its top bit set
    always_comb begin
        num_bit = (cnt_reg == CNT_W'(FRAC_BITS + 1));
        shifted = {rem_reg, num_bit};
        diff    = shifted - {1'b0, divisor};
        fits    = (shifted >= {1'b0, divisor});
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_BITS + 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // quotient and partial remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg  <= diff[DIV_W-1:0];
                quot_reg <= {quot_reg[FRAC_BITS-1:0], 1'b1};
            end else begin
                rem_reg  <= shifted[DIV_W-1:0];
                quot_reg <= {quot_reg[FRAC_BITS-1:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

/* rtl/csr_dp.sv */
`default_nettype none
// ============================================================================
// csr_dp : datapath of the spline rasteriser
// Holds the control points, steps t, and runs an eight-stage pipeline:
// powers of t, basis weights, weighted coordinates, rounding and saturation.
// ============================================================================
module csr_dp import csr_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int IDX_W       = 6
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  ctrl_cmd_t                              cmd,
    output dp_status_t                             status,
    input  logic [IDX_W-1:0]                       last_idx,
    input  logic [NUM_CP-1:0][NUM_CP*COEF_W-1:0]   basis,
    input  logic [COLOR_W-1:0]                     pixel_color,
    input  logic signed [COORD_WIDTH-1:0]          s_p0_x,
    input  logic signed [COORD_WIDTH-1:0]          s_p0_y,
    input  logic signed [COORD_WIDTH-1:0]          s_p1_x,
    input  logic signed [COORD_WIDTH-1:0]          s_p1_y,
    input  logic signed [COORD_WIDTH-1:0]          s_p2_x,
    input  logic signed [COORD_WIDTH-1:0]          s_p2_y,
    input  logic signed [COORD_WIDTH-1:0]          s_p3_x,
    input  logic signed [COORD_WIDTH-1:0]          s_p3_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [COORD_WIDTH-1:0]          m_pixel_x,
    output logic signed [COORD_WIDTH-1:0]          m_pixel_y,
    output logic [COLOR_W-1:0]                     m_color,
    output logic                                   m_last_point
);

    localparam int PW  = FRAC_BITS + 1;         // t and its powers, Q1.F
    localparam int PRW = PW + 1 + COEF_W;       // power times coefficient
    localparam int ACW = PRW + 2;               // sum of four such terms
    localparam int WW  = ACW - COEF_FRAC;       // weight
    localparam int MW  = WW + COORD_WIDTH;      // weight times coordinate
    localparam int SW  = MW + 2;                // sum of four, plus half
    localparam int VW  = SW - FRAC_BITS;        // integer part before saturation
    localparam int NPW = NUM_CP - 1;            // powers that need a multiply

    localparam logic signed [SW-1:0] HALF       = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] TRUNC_BIAS = (SW'(1) << FRAC_BITS) - SW'(1);

    // control points and coefficients
    logic signed [COORD_WIDTH-1:0] px_reg [NUM_CP];
    logic signed [COORD_WIDTH-1:0] py_reg [NUM_CP];
    logic signed [COEF_W-1:0]      coef   [NUM_CP][NUM_CP];

    // t generator
    logic                 div_done;
    logic [PW-1:0]        q_step;
    logic [IDX_W-1:0]     r_step;
    logic [PW-1:0]        t_reg;
    logic [IDX_W-1:0]     r_reg;
    logic [IDX_W:0]       r_sum;
    logic                 wrap;

    // pipeline
    logic                 en;
    logic [7:1]           vld_reg;
    logic [7:1]           last_reg;
    logic [PW-1:0]        t1_reg;
    logic [PW-1:0]        t2a_reg;
    logic [PW-1:0]        t2b_reg;
    logic [PW-1:0]        pw3_reg  [NPW];
    logic signed [PRW-1:0] prod4_reg [NPW][NUM_CP];
    logic signed [WW-1:0]  w5_reg   [NUM_CP];
    logic signed [MW-1:0]  mx6_reg  [NUM_CP];
    logic signed [MW-1:0]  my6_reg  [NUM_CP];
    logic signed [SW-1:0]  sx7_reg;
    logic signed [SW-1:0]  sy7_reg;
    logic                  out_valid_reg;
    logic                  out_last_reg;
    logic signed [COORD_WIDTH-1:0] out_x_reg;
    logic signed [COORD_WIDTH-1:0] out_y_reg;
    logic [COLOR_W-1:0]    out_color_reg;

    logic [2*PW-1:0]       sq_full;
    logic [2*PW-1:0]       cube_full;
    logic signed [PRW-1:0] prod_next [NPW][NUM_CP];
    logic signed [ACW-1:0] acc_next  [NUM_CP];
    logic signed [MW-1:0]  mx_next   [NUM_CP];
    logic signed [MW-1:0]  my_next   [NUM_CP];
    logic signed [SW-1:0]  sx_next;
    logic signed [SW-1:0]  sy_next;

    // the sum arrives with half already added; it is truncated toward zero,
    // followed by saturation to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] trunc_sat(
        input logic signed [SW-1:0] v
    );
        logic signed [SW-1:0]          adj;
        logic [VW-1:0]                 ipart;
        logic signed [COORD_WIDTH-1:0] res;
        adj   = v[SW-1] ? (v + TRUNC_BIAS) : v;
        ipart = adj[SW-1:FRAC_BITS];
        if ((&ipart[VW-1:COORD_WIDTH-1]) || (~|ipart[VW-1:COORD_WIDTH-1])) begin
            res = ipart[COORD_WIDTH-1:0];
        end else if (ipart[VW-1]) begin
            res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    // coefficient unpacking
    always_comb begin
        for (int k = 0; k < NUM_CP; k++) begin
            for (int j = 0; j < NUM_CP; j++) begin
                coef[k][j] = $signed(basis[k][COEF_W*j +: COEF_W]);
            end
        end
    end

    // step division 2^F / (n-1)
    csr_div #(
        .FRAC_BITS (FRAC_BITS),
        .DIV_W     (IDX_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .divisor (last_idx),
        .done    (div_done),
        .quot    (q_step),
        .rem     (r_step)
    );

    // control point capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg[0] <= s_p0_x;
            py_reg[0] <= s_p0_y;
            px_reg[1] <= s_p1_x;
            py_reg[1] <= s_p1_y;
            px_reg[2] <= s_p2_x;
            py_reg[2] <= s_p2_y;
            px_reg[3] <= s_p3_x;
            py_reg[3] <= s_p3_y;
        end
    end

    // t = floor(i * 2^F / d), kept as whole part plus remainder
    always_comb begin
        r_sum = {1'b0, r_reg} + {1'b0, r_step};
        wrap  = (r_sum >= {1'b0, last_idx});
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            t_reg <= '0;
            r_reg <= '0;
        end else if (cmd.issue) begin
            if (wrap) begin
                t_reg <= t_reg + q_step + 1'b1;
                r_reg <= IDX_W'(r_sum - {1'b0, last_idx});
            end else begin
                t_reg <= t_reg + q_step;
                r_reg <= r_sum[IDX_W-1:0];
            end
        end
    end

    // pipeline advances whenever the output register can take a pixel
    assign en = !out_valid_reg || m_ready;

    // stage arithmetic
    always_comb begin
        sq_full   = {{PW{1'b0}}, t1_reg} * {{PW{1'b0}}, t1_reg};
        cube_full = {{PW{1'b0}}, t2b_reg} * {{PW{1'b0}}, t2a_reg};
        for (int k = 0; k < NPW; k++) begin
            for (int j = 0; j < NUM_CP; j++) begin
                prod_next[k][j] = PRW'($signed({1'b0, pw3_reg[k]})) * PRW'(coef[k][j]);
            end
        end
        for (int j = 0; j < NUM_CP; j++) begin
            acc_next[j] = ACW'(prod4_reg[0][j]) + ACW'(prod4_reg[1][j])
                        + ACW'(prod4_reg[2][j]) + (ACW'(coef[NUM_CP-1][j]) <<< FRAC_BITS);
            mx_next[j]  = MW'(w5_reg[j]) * MW'(px_reg[j]);
            my_next[j]  = MW'(w5_reg[j]) * MW'(py_reg[j]);
        end
        sx_next = SW'(mx6_reg[0]) + SW'(mx6_reg[1]) + SW'(mx6_reg[2]) + SW'(mx6_reg[3]) + HALF;
        sy_next = SW'(my6_reg[0]) + SW'(my6_reg[1]) + SW'(my6_reg[2]) + SW'(my6_reg[3]) + HALF;
    end

    // valid and last flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[6:1], cmd.issue};
            out_valid_reg <= vld_reg[7];
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg      <= {last_reg[6:1], cmd.last};
            // stage 1: t
            t1_reg        <= t_reg;
            // stage 2: t^2
            t2a_reg       <= t1_reg;
            t2b_reg       <= sq_full[FRAC_BITS +: PW];
            // stage 3: t^3
            pw3_reg[0]    <= cube_full[FRAC_BITS +: PW];
            pw3_reg[1]    <= t2b_reg;
            pw3_reg[2]    <= t2a_reg;
            // stage 4: power times coefficient
            prod4_reg     <= prod_next;
            // stage 5: weights, floor by 2^12
            for (int j = 0; j < NUM_CP; j++) begin
                w5_reg[j] <= acc_next[j][ACW-1:COEF_FRAC];
            end
            // stage 6: weighted coordinates
            mx6_reg       <= mx_next;
            my6_reg       <= my_next;
            // stage 7: sums plus half
            sx7_reg       <= sx_next;
            sy7_reg       <= sy_next;
            // output register
            out_x_reg     <= trunc_sat(sx7_reg);
            out_y_reg     <= trunc_sat(sy7_reg);
            out_color_reg <= pixel_color;
            out_last_reg  <= last_reg[7];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pixel_x    = out_x_reg;
    assign m_pixel_y    = out_y_reg;
    assign m_color      = out_color_reg;
    assign m_last_point = out_last_reg;

    assign status.div_done   = div_done;
    assign status.pipe_en    = en;
    assign status.pipe_empty = !(|vld_reg) && !out_valid_reg;

endmodule
`default_nettype wire

/* rtl/csr_ctrl.sv */
`default_nettype none
// ============================================================================
// csr_ctrl : segment sequencer
// Accepts a segment, waits for the t-step division, issues one pixel per
// advancing cycle and waits for the pipeline to empty before the next one.
// ============================================================================
module csr_ctrl import csr_pkg::*; #(
    parameter int IDX_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [IDX_W-1:0]  last_idx,
    input  dp_status_t        status,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              is_last;

    assign is_last = (idx_reg == last_idx);

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.issue     = 1'b0;
        cmd.last      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.pipe_en) begin
                    cmd.issue = 1'b1;
                    cmd.last  = is_last;
                    idx_next  = idx_reg + 1'b1;
                    if (is_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (status.pipe_empty) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

/* rtl/cubic_spline_segment_rasterizer.sv */
`default_nettype none
// ============================================================================
// cubic_spline_segment_rasterizer : cubic segment to pixel stream
// Evaluates [t^3 t^2 t 1] * M * [P0..P3] at point_count evenly spaced t and
// emits one rounded, saturated pixel per t with colour and last flag.
// ============================================================================
// One segment is taken at a time. After it is accepted, a serial divider
// works out the t step for the programmed point count n, then n pixels
// enter an eight-stage pipeline, one per cycle while the result side takes
// them, and the segment ends when the last pixel has been taken. The input
// ready rises again once the pipeline has drained. Configuration writes take
// effect at once and belong between segments.
module cubic_spline_segment_rasterizer import csr_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,
    // segment input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_WIDTH-1:0]  s_p0_x,
    input  logic signed [COORD_WIDTH-1:0]  s_p0_y,
    input  logic signed [COORD_WIDTH-1:0]  s_p1_x,
    input  logic signed [COORD_WIDTH-1:0]  s_p1_y,
    input  logic signed [COORD_WIDTH-1:0]  s_p2_x,
    input  logic signed [COORD_WIDTH-1:0]  s_p2_y,
    input  logic signed [COORD_WIDTH-1:0]  s_p3_x,
    input  logic signed [COORD_WIDTH-1:0]  s_p3_y,
    // pixel output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [COORD_WIDTH-1:0]  m_pixel_x,
    output logic signed [COORD_WIDTH-1:0]  m_pixel_y,
    output logic [COLOR_W-1:0]             m_color,
    output logic                           m_last_point
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    logic [NUM_CP-1:0][NUM_CP*COEF_W-1:0] basis_reg;
    logic [POINT_COUNT_W-1:0]             point_count_reg;
    logic [COLOR_W-1:0]                   pixel_color_reg;
    logic [IDX_W-1:0]                     last_idx;
    ctrl_cmd_t                            cmd;
    dp_status_t                           status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            basis_reg       <= '0;
            point_count_reg <= POINT_COUNT_RST;
            pixel_color_reg <= PIXEL_COLOR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index) inside
                REG_BASIS_ROW_0, REG_BASIS_ROW_1, REG_BASIS_ROW_2, REG_BASIS_ROW_3: begin
                    basis_reg[cfg_index[1:0]] <= cfg_wdata;
                end
                REG_POINT_COUNT: begin
                    point_count_reg <= cfg_wdata[POINT_COUNT_W-1:0];
                end
                REG_PIXEL_COLOR: begin
                    pixel_color_reg <= cfg_wdata[COLOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // index of the final pixel, point count clamped to 2..MAX_POINTS
    always_comb begin
        if (point_count_reg < POINT_COUNT_W'(2)) begin
            last_idx = IDX_W'(1);
        end else if (point_count_reg > POINT_COUNT_W'(MAX_POINTS)) begin
            last_idx = IDX_W'(MAX_POINTS - 1);
        end else begin
            last_idx = IDX_W'(point_count_reg - 1'b1);
        end
    end

    csr_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .last_idx (last_idx),
        .status   (status),
        .cmd      (cmd)
    );

    csr_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .last_idx     (last_idx),
        .basis        (basis_reg),
        .pixel_color  (pixel_color_reg),
        .s_p0_x       (s_p0_x),
        .s_p0_y       (s_p0_y),
        .s_p1_x       (s_p1_x),
        .s_p1_y       (s_p1_y),
        .s_p2_x       (s_p2_x),
        .s_p2_y       (s_p2_y),
        .s_p3_x       (s_p3_x),
        .s_p3_y       (s_p3_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_color      (m_color),
        .m_last_point (m_last_point)
    );

    // a new segment is only taken with nothing left in flight
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> status.pipe_empty)
        else $error("segment input ready while pixels still in flight");

    // the final pixel of a segment leaves the pipeline empty behind it
    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_point) |=> status.pipe_empty)
        else $error("pixels remain after the last pixel of a segment");

    // the step division only completes inside a segment
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> !s_ready)
        else $error("step division finished while idle");

endmodule
`default_nettype wire
